/* design/ffsa_pkg.sv */
// Shared types, constants and result codes of the first-fit segment allocator.
package ffsa_pkg;

  localparam int unsigned MaxSegmentsDefault = 64;
  localparam int unsigned AddressBits = 20;

  localparam int unsigned CfgWidth = 21;
  localparam int unsigned CfgIndexWidth = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_BASE     = 2'd1,
    CFG_FIRST    = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    RC_DONE    = 3'd0,
    RC_BAD_END = 3'd1,
    RC_NO_FIT  = 3'd2,
    RC_FULL    = 3'd3,
    RC_INVALID = 3'd4
  } result_code_e;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [19:0] end_address;
    logic [20:0] request_size;
    logic        match_status;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [19:0] block_start;
    logic [19:0] block_end;
    logic        block_status;
    logic        load_complete;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RD_NEXT,
    ST_FIX,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_e;

endpackage

/* design/first_fit_segment_allocator_core.sv */
// Top level of the first-fit segment allocator: control sequencer and segment table memory.
//
// Usage: items arrive on the in channel (in_valid_i/in_ready_o/in_data_i) and each one
// produces exactly one result on the out channel (out_valid_o/out_ready_i/out_data_o).
// Opcode 0 loads the next segment end; opcode 1 requests a flip of units.
// The segment table sits in one synchronous memory with a registered read port;
// each entry packs start, end and status.
// A load or a rejected request passes through the response state before its result shows.
// A request reads and then checks one entry at a time until the first fit, fixes up
// the neighbouring entries, then reads and writes each entry that is moved when a
// segment is inserted or removed.
// One item is in work at a time; in_ready_o is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls the block holds it
// and accepts no new item.
// Reset clears the segment count and the load state to start zero and status zero, and
// sets the capacity to 2^20; the table memory is not cleared, since only entries below
// the count are ever used.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) belong between items.
module first_fit_segment_allocator_core
  import ffsa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  req_t                     in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rsp_t                     out_data_o
);

  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW   = AddressBits;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [AW-1:0] s;
    logic [AW-1:0] e;
    logic          st;
  } ent_t;

  // Segment table memory.
  ent_t            mem_q [MAX_SEGMENTS];
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  ent_t            wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Configuration and load state.
  logic [CfgWidth-1:0] cap_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]       nls_q, nls_d;
  logic                nlst_q, nlst_d, done_q, done_d;

  state_e          st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] k_q, k_d;
  req_t            req_q;
  ent_t            cur_q, cur_d, nxt_q, nxt_d, prv_q, prv_d;
  logic            up_q, up_d;     // shift direction: 1 moves entries up (insert)
  logic [1:0]      rm_q, rm_d;     // number of entries removed, the distance entries move down
  ent_t            ins_q, ins_d;
  rsp_t            rsp_q, rsp_d;
  logic            ov_q, ov_d;

  // Effective capacity clamped to 1 .. 2^AW, held one bit wider than the address.
  logic [AW:0] cap_eff;
  always_comb begin
    logic [CfgWidth:0] c;
    c = {1'b0, cap_q};
    if (c == '0) c = (CfgWidth+1)'(1);
    if (c > (CfgWidth+1)'(1) << AW) c = (CfgWidth+1)'(1) << AW;
    cap_eff = c[AW:0];
  end

  logic [AW-1:0] endv;
  assign endv = AW'(in_data_i.end_address);

  // Fit test for the entry in the read register.
  logic [AW:0] len_cur;
  logic        fits;
  assign len_cur = {1'b0, rdata_q.e} - {1'b0, rdata_q.s} + 1'b1;
  assign fits = (rdata_q.st == req_q.match_status) && (rdata_q.e >= rdata_q.s) &&
                ({{(22 - AW - 1) {1'b0}}, len_cur} >= {1'b0, req_q.request_size});

  logic [AW:0] len_sel;
  logic        partial;
  assign len_sel = {1'b0, cur_q.e} - {1'b0, cur_q.s} + 1'b1;
  assign partial = {1'b0, req_q.request_size} < {{(22 - AW - 1) {1'b0}}, len_sel};

  logic [AW-1:0] sz;
  assign sz = AW'(req_q.request_size);

  logic has_prev, has_next;
  assign has_prev = idx_q != '0;
  assign has_next = (CntW'(idx_q) + 1'b1) < cnt_q;

  assign in_ready_o  = (st_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    k_d   = k_q;
    cur_d = cur_q;
    nxt_d = nxt_q;
    prv_d = prv_q;
    up_d  = up_q;
    rm_d  = rm_q;
    ins_d = ins_q;
    rsp_d = rsp_q;
    ov_d  = ov_q;
    cnt_d = cnt_q;
    nls_d = nls_q;
    nlst_d = nlst_q;
    done_d = done_q;
    we    = 1'b0;
    waddr = idx_q;
    wdata = cur_q;
    raddr = idx_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          rsp_d = '0;
          idx_d = '0;
          if (in_data_i.opcode == OP_LOAD) begin
            rsp_d.block_start  = 20'(nls_q);
            rsp_d.block_end    = 20'(endv);
            rsp_d.block_status = nlst_q;
            if (done_q) begin
              rsp_d = '0;
              rsp_d.result_code = RC_INVALID;
            end else if (endv < nls_q || {1'b0, endv} >= cap_eff) begin
              rsp_d.result_code = RC_BAD_END;
            end else if (cnt_q >= MaxCnt) begin
              rsp_d.result_code = RC_FULL;
            end else begin
              rsp_d.result_code = RC_DONE;
              we    = 1'b1;
              waddr = IdxW'(cnt_q);
              wdata = '{s: nls_q, e: endv, st: nlst_q};
              cnt_d = cnt_q + 1'b1;
              if ({1'b0, endv} >= cap_eff - 1'b1) begin
                done_d = 1'b1;
              end else begin
                nls_d  = endv + 1'b1;
                nlst_d = ~nlst_q;
              end
            end
            rsp_d.load_complete = done_d;
            st_d = ST_RESP;
          end else if (!done_q || in_data_i.request_size == '0) begin
            rsp_d.result_code   = RC_INVALID;
            rsp_d.load_complete = done_q;
            st_d = ST_RESP;
          end else begin
            raddr = '0;
            st_d  = ST_SCAN_CHK;
          end
        end
      end
      ST_SCAN_RD: begin
        raddr = idx_q;
        st_d  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (fits) begin
          cur_d = rdata_q;
          rsp_d.block_start  = 20'(rdata_q.s);
          rsp_d.block_end    = 20'(rdata_q.e);
          rsp_d.block_status = rdata_q.st;
          raddr = idx_q + 1'b1;
          st_d  = ST_RD_NEXT;
        end else if ((CntW'(idx_q) + 1'b1) >= cnt_q) begin
          rsp_d.result_code   = RC_NO_FIT;
          rsp_d.load_complete = done_q;
          st_d = ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = ST_SCAN_RD;
        end
        // Keep the previous entry for the predecessor fix-up.
        if (!fits) prv_d = rdata_q;
      end
      ST_RD_NEXT: begin
        nxt_d = rdata_q;
        st_d  = ST_FIX;
      end
      ST_FIX: begin
        rsp_d.result_code   = RC_DONE;
        rsp_d.load_complete = done_q;
        st_d = ST_RESP;
        if (partial) begin
          if (!has_prev) begin
            if (cnt_q >= MaxCnt) begin
              rsp_d.result_code = RC_FULL;
            end else begin
              // Move entries 0..count-1 up by one, then write the new head.
              up_d  = 1'b1;
              ins_d = '{s: cur_q.s, e: cur_q.s + sz - 1'b1, st: ~cur_q.st};
              cur_d.s = cur_q.s + sz;
              k_d   = cnt_q;
              cnt_d = cnt_q + 1'b1;
              st_d  = ST_SHIFT_RD;
            end
          end else begin
            we    = 1'b1;
            waddr = idx_q - 1'b1;
            wdata = '{s: prv_q.s, e: prv_q.e + sz, st: prv_q.st};
            cur_d.s = cur_q.s + sz;
            st_d  = ST_SHIFT_RD;
            rm_d  = 2'd0;
            up_d  = 1'b0;
            k_d   = cnt_q; // nothing to move; the shift states write cur back
          end
        end else if (!has_prev && !has_next) begin
          we    = 1'b1;
          wdata = '{s: cur_q.s, e: cur_q.e, st: ~cur_q.st};
        end else if (!has_prev) begin
          we    = 1'b1;
          wdata = '{s: cur_q.s, e: nxt_q.e, st: ~cur_q.st};
          up_d  = 1'b0;
          k_d   = CntW'(idx_q) + 2'd2;
          idx_d = idx_q + 1'b1;
          cnt_d = cnt_q - 1'b1;
          st_d  = ST_SHIFT_RD;
          rm_d  = 2'd1;
        end else if (!has_next) begin
          we    = 1'b1;
          waddr = idx_q - 1'b1;
          wdata = '{s: prv_q.s, e: cur_q.e, st: prv_q.st};
          cnt_d = cnt_q - 1'b1;
        end else begin
          we    = 1'b1;
          waddr = idx_q - 1'b1;
          wdata = '{s: prv_q.s, e: nxt_q.e, st: prv_q.st};
          up_d  = 1'b0;
          k_d   = CntW'(idx_q) + 2'd2;
          cnt_d = cnt_q - 2'd2;
          st_d  = ST_SHIFT_RD;
          rm_d  = 2'd2;
        end
      end
      ST_SHIFT_RD: begin
        if (up_q) begin
          if (k_q == CntW'(idx_q)) begin
            // All moved: entry 1 gets the trimmed segment, entry 0 the new one.
            we    = 1'b1;
            waddr = '0;
            wdata = ins_q;
            st_d  = ST_SHIFT_WR;
            k_d   = '1;
          end else begin
            raddr = IdxW'(k_q - 1'b1);
            st_d  = ST_SHIFT_WR;
          end
        end else if (rm_q == 2'd0) begin
          we    = 1'b1;
          wdata = cur_q;
          st_d  = ST_RESP;
        end else if (k_q >= cnt_q + CntW'(rm_q)) begin
          st_d = ST_RESP;
        end else begin
          raddr = IdxW'(k_q);
          st_d  = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        if (up_q) begin
          if (k_q == '1) begin
            we    = 1'b1;
            waddr = IdxW'(1);
            wdata = cur_q;
            st_d  = ST_RESP;
          end else begin
            we    = 1'b1;
            waddr = IdxW'(k_q);
            wdata = rdata_q;
            k_d   = k_q - 1'b1;
            st_d  = ST_SHIFT_RD;
          end
        end else begin
          we    = 1'b1;
          waddr = IdxW'(k_q - CntW'(rm_q));
          wdata = rdata_q;
          k_d   = k_q + 1'b1;
          st_d  = ST_SHIFT_RD;
        end
      end
      ST_RESP: begin
        ov_d = 1'b1;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    // While the table is empty, base address and first status also seed the load state.
    if (cfg_we_i && cnt_q == '0) begin
      if (cfg_index_i == CFG_BASE) nls_d = AW'(cfg_data_i[19:0]);
      if (cfg_index_i == CFG_FIRST) nlst_d = cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      nls_q   <= '0;
      nlst_q  <= 1'b0;
      cap_q   <= CfgWidth'(1) << 20;
    end else begin
      st_q   <= st_d;
      ov_q   <= ov_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
      nls_q  <= nls_d;
      nlst_q <= nlst_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CAPACITY: cap_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    k_q   <= k_d;
    cur_q <= cur_d;
    nxt_q <= nxt_d;
    prv_q <= prv_d;
    up_q  <= up_d;
    rm_q  <= rm_d;
    ins_q <= ins_d;
    rsp_q <= rsp_d;
    if (st_q == ST_IDLE && in_valid_i && in_ready_o) req_q <= in_data_i;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("segment count above table depth");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (st_q == ST_IDLE && !out_valid_o))
    else $error("ready while busy");
  a_done_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q) else $error("load complete dropped");
  a_resp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_RESP |=> out_valid_o) else $error("result not presented");

endmodule
